@@ hw/rtl/sorted_list_insert_delete_unit_defines.svh @@
// Assertion macros used by the sorted list top module.
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLID_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SLID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLID_ASSERT_SAME(lbl, ante, cons, msg)
`define SLID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/slid_pkg.sv @@
// Package: command and status codes and the cell control bundle.
package slid_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned CountOutWidth = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // broadcast to every cell for the item being accepted
  typedef struct packed {
    logic ins;
    logic pop;
    logic del;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/slid_cell.sv @@
// One list cell: holds an entry, compares it to the item value, shifts with neighbors.
module slid_cell (
  input  logic                                   clk,
  input  slid_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [slid_pkg::ValueWidth-1:0] value,
  input  logic                                   occ,
  input  logic                                   prev_ge_ins,
  input  logic                                   prev_ge_del,
  input  logic signed [slid_pkg::ValueWidth-1:0] left_entry,
  input  logic signed [slid_pkg::ValueWidth-1:0] right_entry,
  output logic                                   ge_ins,
  output logic                                   ge_del,
  output logic                                   hit,
  output logic signed [slid_pkg::ValueWidth-1:0] entry
);

  logic signed [slid_pkg::ValueWidth-1:0] entry_r;
  logic signed [slid_pkg::ValueWidth-1:0] entry_nxt;
  logic                                   at_or_above;

  assign at_or_above = (entry_r >= value);
  // empty cells count as above, so the insert point is the first such cell
  assign ge_ins = !occ || at_or_above;
  assign ge_del = occ && at_or_above;
  // list is sorted: the first equal entry sits at the first cell at or above
  assign hit    = ge_del && !prev_ge_del && (entry_r == value);
  assign entry  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctrl.ins) begin
      if (ge_ins && !prev_ge_ins) begin
        entry_nxt = value;
      end else if (ge_ins) begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end else if (ctrl.del && ge_del) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

@@ hw/rtl/sorted_list_insert_delete_unit.sv @@
// Sorted list priority queue: up to CAPACITY signed values in ascending order,
// held in a row of cells that each compare against the item value at once and
// shift left or right together. Insert, pop-smallest and delete-first-equal
// need no busy state, so one item is accepted every cycle; the result shows in
// the output register the cycle after acceptance. The input stalls only while a
// result waits in the output register under out_stall. The longest path is the
// compare in every cell plus the OR of their match flags that decides a delete.
`include "sorted_list_insert_delete_unit_defines.svh"

module sorted_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_cmd,
  input  logic signed [slid_pkg::ValueWidth-1:0] in_item_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_status,
  output logic                                   out_now_empty,
  output logic [slid_pkg::CountOutWidth-1:0]     out_entry_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                          count_r;
  logic [CW-1:0]                          cnt_nxt;
  logic                                   in_acc;
  logic                                   found;
  logic                                   full_rej;
  slid_pkg::status_t                      status_nxt;
  slid_pkg::cell_ctrl_t                   ctrl;

  logic                                   out_valid_r;
  logic [1:0]                             out_status_r;
  logic                                   out_now_empty_r;
  logic [slid_pkg::CountOutWidth-1:0]     out_entry_count_r;
  logic [CW+slid_pkg::CountOutWidth-1:0]  count_ext;

  logic [CAPACITY-1:0]                    occ;
  logic [CAPACITY-1:0]                    ge_ins;
  logic [CAPACITY-1:0]                    ge_del;
  logic [CAPACITY-1:0]                    hit;
  logic signed [slid_pkg::ValueWidth-1:0] entries [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign found    = |hit;
  assign full_rej = in_acc && (status_nxt == slid_pkg::ST_FULL);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                   p_ins;
    logic                                   p_del;
    logic signed [slid_pkg::ValueWidth-1:0] l_ent;
    logic signed [slid_pkg::ValueWidth-1:0] r_ent;

    assign occ[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign p_ins = 1'b0;
      assign p_del = 1'b0;
      assign l_ent = in_item_value;
    end else begin : g_mid
      assign p_ins = ge_ins[i-1];
      assign p_del = ge_del[i-1];
      assign l_ent = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = entries[i];
    end else begin : g_inner
      assign r_ent = entries[i+1];
    end

    slid_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .value       (in_item_value),
      .occ         (occ[i]),
      .prev_ge_ins (p_ins),
      .prev_ge_del (p_del),
      .left_entry  (l_ent),
      .right_entry (r_ent),
      .ge_ins      (ge_ins[i]),
      .ge_del      (ge_del[i]),
      .hit         (hit[i]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    ctrl       = '0;
    status_nxt = slid_pkg::ST_OK;
    cnt_nxt    = count_r;
    unique case (in_cmd)
      slid_pkg::CMD_INSERT: begin
        if (count_r == CW'(CAPACITY)) begin
          status_nxt = slid_pkg::ST_FULL;
        end else begin
          ctrl.ins = in_acc;
          cnt_nxt  = count_r + CW'(1);
        end
      end
      slid_pkg::CMD_POP: begin
        if (count_r == '0) begin
          status_nxt = slid_pkg::ST_EMPTY;
        end else begin
          ctrl.pop = in_acc;
          cnt_nxt  = count_r - CW'(1);
        end
      end
      slid_pkg::CMD_DELETE: begin
        if (count_r == '0) begin
          status_nxt = slid_pkg::ST_EMPTY;
        end else if (!found) begin
          status_nxt = slid_pkg::ST_NOT_FOUND;
        end else begin
          ctrl.del = in_acc;
          cnt_nxt  = count_r - CW'(1);
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  assign count_ext = {{slid_pkg::CountOutWidth{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r      <= status_nxt;
      out_now_empty_r   <= (cnt_nxt == '0);
      out_entry_count_r <= count_ext[slid_pkg::CountOutWidth-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_now_empty   = out_now_empty_r;
  assign out_entry_count = out_entry_count_r;

  `SLID_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `SLID_ASSERT_SAME(a_single_hit, 1'b1, $onehot0(hit), "more than one delete match")
  `SLID_ASSERT_NEXT(a_insert_count, ctrl.ins, count_r == $past(count_r) + CW'(1), "insert count")
  `SLID_ASSERT_SAME(a_full_status, full_rej, count_r == CW'(CAPACITY), "full status while not full")

endmodule
